// ===== src/utcc_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text console cursor package
// Shared types and constants: register indexes, byte-decode patterns,
// codepoint ranges and font codes.
// ----------------------------------------------------------------------------
package utcc_pkg;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_SCREEN_WIDTH  = 2'd0;
    localparam t_cfg_index CFG_SCREEN_HEIGHT = 2'd1;
    localparam t_cfg_index CFG_CHAR_SCALE    = 2'd2;

    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned PX_W       = 12;
    localparam int unsigned CP_W       = 21;
    localparam int unsigned SCALE_W    = 4;

    localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;
    localparam logic [SCALE_W-1:0]    CHAR_SCALE_RESET    = 4'd1;
    localparam logic [CFG_DATA_W-1:0] SCREEN_MIN          = 13'd1;
    localparam logic [CFG_DATA_W-1:0] SCREEN_MAX          = 13'd4096;
    localparam logic [CFG_DATA_W-1:0] SCALE_MIN           = 13'd1;
    localparam logic [CFG_DATA_W-1:0] SCALE_MAX           = 13'd8;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'h3F;

    localparam logic [CP_W-1:0] CP_NEWLINE     = 21'h0000A;
    localparam logic [CP_W-1:0] CP_RETURN      = 21'h0000D;
    localparam logic [CP_W-1:0] CP_ASCII_FIRST = 21'h00020;
    localparam logic [CP_W-1:0] CP_ASCII_LAST  = 21'd126;
    localparam logic [CP_W-1:0] CP_BOX_FIRST   = 21'h02500;
    localparam logic [CP_W-1:0] CP_BOX_LAST    = 21'h0257F;
    localparam logic [CP_W-1:0] CP_BRL_FIRST   = 21'h02800;
    localparam logic [CP_W-1:0] CP_BRL_LAST    = 21'h028FF;

    typedef enum logic [1:0] {
        FONT_ASCII   = 2'd0,
        FONT_BOX     = 2'd1,
        FONT_BRAILLE = 2'd2
    } t_font;

endpackage

// ===== src/utf8_text_console_cursor.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text console cursor
// Decodes a UTF-8 byte stream into glyph draw commands at the cursor cell
// and tracks the cursor with wrap and scroll requests.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         tdata[7:0]: text byte
//  m_axis    out        one result per byte, 64-bit tdata
//  cfg       in         register index and 13-bit write data
//
//  Each byte passes an input register, then the decode and cursor update
//  into the result register. One byte per cycle is sustained while the result
//  is not stalled; the cursor add and compare in the update stage sets that.
//  Reset is synchronous and active low and restores the register defaults.
//  A stalled result holds both stages; the input side keeps accepting while
//  the input register is empty or moving on.
module utf8_text_console_cursor
    import utcc_pkg::*;
#(
    parameter int unsigned GLYPH_WIDTH  = 8,
    parameter int unsigned GLYPH_HEIGHT = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] text_byte
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] draw_valid, [2:1] font_select, [10:3] glyph_index, [22:11] cell_x,
    // [34:23] cell_y, [35] scroll_up, [47:36] cursor_x, [59:48] cursor_y,
    // [63:60] zero
    output logic [63:0]           o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned CELL_W_BITS = $clog2(GLYPH_WIDTH * 8 + 1);
    localparam int unsigned CELL_H_BITS = $clog2(GLYPH_HEIGHT * 8 + 1);

    logic [CFG_DATA_W-1:0] r_width, n_width;
    logic [CFG_DATA_W-1:0] r_height, n_height;
    logic [SCALE_W-1:0]    r_scale, n_scale;

    logic                  r_in_valid, n_in_valid;
    logic [7:0]            r_in_byte, n_in_byte;

    logic [1:0]            r_pending, n_pending;
    logic [CP_W-1:0]       r_partial, n_partial;
    logic [PX_W-1:0]       r_col, n_col;
    logic [PX_W-1:0]       r_row, n_row;

    logic                  r_out_valid, n_out_valid;
    logic [63:0]           r_out_data, n_out_data;

    logic                  out_free;
    logic                  step;
    logic [CELL_W_BITS-1:0] cell_w;
    logic [CELL_H_BITS-1:0] cell_h;
    logic                  cp_done;
    logic [CP_W-1:0]       cp;
    logic                  draw;
    t_font                 font;
    logic [7:0]            glyph;
    logic [PX_W:0]         row_step;
    logic                  row_over;
    logic [PX_W-1:0]       row_floor;
    logic [PX_W-1:0]       nl_row;
    logic [PX_W:0]         col_adv;
    logic                  wrap;
    logic                  scroll;
    logic [PX_W-1:0]       cx0, cy0;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    assign cell_w = CELL_W_BITS'(32'(r_scale) * GLYPH_WIDTH);
    assign cell_h = CELL_H_BITS'(32'(r_scale) * GLYPH_HEIGHT);

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_scale  = r_scale;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH: begin
                    if (i_cfg_data >= SCREEN_MIN && i_cfg_data <= SCREEN_MAX) begin
                        n_width = i_cfg_data;
                    end
                end
                CFG_SCREEN_HEIGHT: begin
                    if (i_cfg_data >= SCREEN_MIN && i_cfg_data <= SCREEN_MAX) begin
                        n_height = i_cfg_data;
                    end
                end
                CFG_CHAR_SCALE: begin
                    if (i_cfg_data >= SCALE_MIN && i_cfg_data <= SCALE_MAX) begin
                        n_scale = i_cfg_data[SCALE_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        cp_done   = 1'b0;
        cp        = '0;
        if (r_pending != 2'd0) begin
            n_partial = {r_partial[CP_W-7:0], r_in_byte[5:0] & CONT_MASK[5:0]};
            n_pending = r_pending - 2'd1;
            if (r_pending == 2'd1) begin
                cp_done = 1'b1;
                cp      = n_partial;
            end
        end else if (!r_in_byte[7]) begin
            cp_done = 1'b1;
            cp      = CP_W'(r_in_byte);
        end else if ((r_in_byte & LEAD2_MASK) == LEAD2_CODE) begin
            n_partial = CP_W'(r_in_byte[4:0]);
            n_pending = 2'd1;
        end else if ((r_in_byte & LEAD3_MASK) == LEAD3_CODE) begin
            n_partial = CP_W'(r_in_byte[3:0]);
            n_pending = 2'd2;
        end else if ((r_in_byte & LEAD4_MASK) == LEAD4_CODE) begin
            n_partial = CP_W'(r_in_byte[2:0]);
            n_pending = 2'd3;
        end
    end

    always_comb begin
        draw  = 1'b0;
        font  = FONT_ASCII;
        glyph = '0;
        if (cp_done) begin
            if (cp >= CP_BOX_FIRST && cp <= CP_BOX_LAST) begin
                draw  = 1'b1;
                font  = FONT_BOX;
                glyph = 8'(cp - CP_BOX_FIRST);
            end else if (cp >= CP_BRL_FIRST && cp <= CP_BRL_LAST) begin
                draw  = 1'b1;
                font  = FONT_BRAILLE;
                glyph = 8'(cp - CP_BRL_FIRST);
            end else if (cp >= CP_ASCII_FIRST && cp <= CP_ASCII_LAST) begin
                draw  = 1'b1;
                font  = FONT_ASCII;
                glyph = cp[7:0];
            end
        end
    end

    always_comb begin
        row_step  = {1'b0, r_row} + (PX_W + 1)'(cell_h);
        row_over  = ({1'b0, row_step} + (PX_W + 2)'(cell_h)) > {1'b0, r_height};
        row_floor = (r_height >= CFG_DATA_W'(cell_h))
                  ? PX_W'(r_height - CFG_DATA_W'(cell_h)) : '0;
        nl_row    = row_over ? row_floor : row_step[PX_W-1:0];
        col_adv   = {1'b0, r_col} + (PX_W + 1)'(cell_w);
        wrap      = ({1'b0, col_adv} + (PX_W + 2)'(cell_w)) > {1'b0, r_width};
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        scroll = 1'b0;
        cx0    = '0;
        cy0    = '0;
        if (cp_done && cp == CP_NEWLINE) begin
            n_col  = '0;
            n_row  = nl_row;
            scroll = row_over;
        end else if (cp_done && cp == CP_RETURN) begin
            n_col = '0;
        end else if (draw) begin
            cx0 = r_col;
            cy0 = r_row;
            if (wrap) begin
                n_col  = '0;
                n_row  = nl_row;
                scroll = row_over;
            end else begin
                n_col = col_adv[PX_W-1:0];
            end
        end
    end

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_byte   = r_in_byte;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (o_s_axis_tready) begin
            n_in_valid = i_s_axis_tvalid;
            n_in_byte  = i_s_axis_tdata;
        end
        if (out_free) begin
            n_out_valid = r_in_valid;
        end
        if (step) begin
            n_out_data = {4'd0, n_row, n_col, scroll, cy0, cx0, glyph, font, draw};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= SCREEN_WIDTH_RESET;
            r_height    <= SCREEN_HEIGHT_RESET;
            r_scale     <= CHAR_SCALE_RESET;
            r_in_valid  <= 1'b0;
            r_pending   <= '0;
            r_partial   <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_width     <= n_width;
            r_height    <= n_height;
            r_scale     <= n_scale;
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (step) begin
                r_pending <= n_pending;
                r_partial <= n_partial;
                r_col     <= n_col;
                r_row     <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte  <= n_in_byte;
        r_out_data <= n_out_data;
    end

endmodule

// ===== verif/tb_utf8_text_console_cursor.sv =====
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 text console cursor
// Streams directed and random UTF-8 text through the block under several
// screen and scale settings and idle patterns, predicts every result with a
// behavioral decoder and cursor tracker, and compares each result field.
// ----------------------------------------------------------------------------
module tb_utf8_text_console_cursor;
    import utcc_pkg::*;

    localparam int unsigned CELL_W_BASE = 8;
    localparam int unsigned CELL_H_BASE = 8;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned MAX_PRINTS  = 40;
    localparam t_cfg_index  CFG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [3:0]  pad;
        logic [11:0] cur_y;
        logic [11:0] cur_x;
        logic        scroll;
        logic [11:0] cell_y;
        logic [11:0] cell_x;
        logic [7:0]  glyph;
        logic [1:0]  font;
        logic        draw;
    } t_console_res;

    typedef struct packed {
        t_cfg_index            idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = 8'h00;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [63:0]           o_m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_index            i_cfg_index = CFG_SCREEN_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor copy of the registers and the decode and cursor state.
    int unsigned   scr_width  = 32'(SCREEN_WIDTH_RESET);
    int unsigned   scr_height = 32'(SCREEN_HEIGHT_RESET);
    int unsigned   scale      = 32'(CHAR_SCALE_RESET);
    logic [1:0]    cont_left  = '0;
    logic [CP_W-1:0] cp_accum = '0;
    int unsigned   col_px     = 0;
    int unsigned   row_px     = 0;

    t_console_res  expected_results[$];
    t_reg_write    reg_writes[$];

    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    int unsigned hold_left  = 0;
    int unsigned quiet      = 0;
    int unsigned n_bytes    = 0;
    int unsigned n_results  = 0;
    int unsigned n_draws    = 0;
    int unsigned n_scrolls  = 0;
    int unsigned n_settings = 0;
    int unsigned n_errors   = 0;

    utf8_text_console_cursor #(
        .GLYPH_WIDTH (CELL_W_BASE),
        .GLYPH_HEIGHT(CELL_H_BASE)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic line_feed(input int unsigned cell_h);
        logic scrolled;
        scrolled = 1'b0;
        col_px = 0;
        row_px = row_px + cell_h;
        if (row_px + cell_h > scr_height) begin
            scrolled = 1'b1;
            row_px = (scr_height >= cell_h) ? scr_height - cell_h : 0;
        end
        row_px = row_px & 32'hFFF;
        return scrolled;
    endfunction

    function automatic t_console_res console_step(input logic [7:0] b);
        t_console_res r;
        int unsigned  cell_w;
        int unsigned  cell_h;
        int unsigned  cp;
        logic         done;
        r = '0;
        done = 1'b0;
        cp = 0;
        cell_w = CELL_W_BASE * scale;
        cell_h = CELL_H_BASE * scale;
        if (cont_left != 0) begin
            cp_accum = {cp_accum[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 0) begin
                done = 1'b1;
                cp = 32'(cp_accum);
            end
        end else if (!b[7]) begin
            done = 1'b1;
            cp = 32'(b);
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            cp_accum = CP_W'(b[4:0]);
            cont_left = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            cp_accum = CP_W'(b[3:0]);
            cont_left = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            cp_accum = CP_W'(b[2:0]);
            cont_left = 2'd3;
        end
        if (done && cp != 0) begin
            if (cp == CP_NEWLINE) begin
                r.scroll = line_feed(cell_h);
            end else if (cp == CP_RETURN) begin
                col_px = 0;
            end else begin
                if (cp >= CP_BOX_FIRST && cp <= CP_BOX_LAST) begin
                    r.draw = 1'b1;
                    r.font = FONT_BOX;
                    r.glyph = 8'(cp - CP_BOX_FIRST);
                end else if (cp >= CP_BRL_FIRST && cp <= CP_BRL_LAST) begin
                    r.draw = 1'b1;
                    r.font = FONT_BRAILLE;
                    r.glyph = 8'(cp - CP_BRL_FIRST);
                end else if (cp >= CP_ASCII_FIRST && cp <= CP_ASCII_LAST) begin
                    r.draw = 1'b1;
                    r.font = FONT_ASCII;
                    r.glyph = 8'(cp);
                end
                if (r.draw) begin
                    r.cell_x = PX_W'(col_px);
                    r.cell_y = PX_W'(row_px);
                    col_px = col_px + cell_w;
                    if (col_px + cell_w > scr_width) begin
                        r.scroll = line_feed(cell_h);
                    end
                    col_px = col_px & 32'hFFF;
                end
            end
        end
        r.cur_x = PX_W'(col_px);
        r.cur_y = PX_W'(row_px);
        return r;
    endfunction

    function automatic void apply_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_SCREEN_WIDTH: begin
                if (d >= SCREEN_MIN && d <= SCREEN_MAX) scr_width = 32'(d);
            end
            CFG_SCREEN_HEIGHT: begin
                if (d >= SCREEN_MIN && d <= SCREEN_MAX) scr_height = 32'(d);
            end
            CFG_CHAR_SCALE: begin
                if (d >= SCALE_MIN && d <= SCALE_MAX) scale = 32'(d);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        n_errors++;
        if (n_errors <= MAX_PRINTS) begin
            $display("mismatch at result %0d: %s expected %0d, got %0d",
                     n_results, what, want, got);
        end
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) report_mismatch(what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_console_res got;
        t_console_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", 0, 1);
            end else begin
                want = expected_results.pop_front();
                n_results++;
                n_draws += want.draw;
                n_scrolls += want.scroll;
                check_field("draw_valid", want.draw, got.draw);
                check_field("font_select", want.font, got.font);
                check_field("glyph_index", want.glyph, got.glyph);
                check_field("cell_x", want.cell_x, got.cell_x);
                check_field("cell_y", want.cell_y, got.cell_y);
                check_field("scroll_up", want.scroll, got.scroll);
                check_field("cursor_x", want.cur_x, got.cur_x);
                check_field("cursor_y", want.cur_y, got.cur_y);
                check_field("padding", want.pad, got.pad);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Leaves tvalid high after the transaction; the next call or drain_results
    // decides whether it stays high.
    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_results.push_back(console_step(b));
        n_bytes++;
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_regs();
        t_reg_write w;
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.idx;
            i_cfg_data <= w.data;
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_reg(w.idx, w.data);
        end
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic set_screen(input int unsigned w, input int unsigned h, input int unsigned s);
        reg_writes.push_back('{CFG_SCREEN_WIDTH, CFG_DATA_W'(w)});
        reg_writes.push_back('{CFG_SCREEN_HEIGHT, CFG_DATA_W'(h)});
        reg_writes.push_back('{CFG_CHAR_SCALE, CFG_DATA_W'(s)});
        write_regs();
    endtask

    task automatic put_string(input logic [7:0] bytes[$]);
        foreach (bytes[i]) put_byte(bytes[i]);
    endtask

    // Sends the first count bytes of a len-byte encoding of cp.
    task automatic put_codepoint(input logic [20:0] cp, input int unsigned len,
                                 input int unsigned count, input bit junk_tops);
        logic [7:0] seq [4];
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 1; i < 4; i++) begin
            if (junk_tops) seq[i][7:6] = 2'($urandom_range(3));
        end
        for (int i = 0; i < count; i++) put_byte(seq[i]);
    endtask

    task automatic put_random_text();
        int unsigned sel;
        int unsigned cp;
        int unsigned len;
        sel = $urandom_range(99);
        if (sel < 8) begin
            put_byte(8'($urandom_range(255)));
            return;
        end
        sel = $urandom_range(99);
        if (sel < 35)      cp = $urandom_range(CP_ASCII_LAST, CP_ASCII_FIRST);
        else if (sel < 45) cp = 32'(CP_NEWLINE);
        else if (sel < 50) cp = 32'(CP_RETURN);
        else if (sel < 70) cp = $urandom_range(CP_BOX_LAST, CP_BOX_FIRST);
        else if (sel < 85) cp = $urandom_range(CP_BRL_LAST, CP_BRL_FIRST);
        else               cp = $urandom_range(21'h1FFFFF, 1);
        if (cp < 'h80)         len = 1;
        else if (cp < 'h800)   len = 2;
        else if (cp < 'h10000) len = 3;
        else                   len = 4;
        if (len < 4 && $urandom_range(9) == 0) len++;
        if (len > 1 && $urandom_range(99) < 5) begin
            put_codepoint(CP_W'(cp), len, $urandom_range(len - 1, 1), 1'b1);
        end else begin
            put_codepoint(CP_W'(cp), len, len, $urandom_range(19) == 0);
        end
    endtask

    task automatic queue_random_settings();
        int unsigned w;
        int unsigned h;
        case ($urandom_range(3))
            0: w = $urandom_range(64, 1);
            1: w = $urandom_range(600, 65);
            2: w = $urandom_range(SCREEN_MAX, SCREEN_MIN);
            default: w = 32'(SCREEN_MAX);
        endcase
        case ($urandom_range(3))
            0: h = $urandom_range(64, 1);
            1: h = $urandom_range(600, 65);
            2: h = $urandom_range(SCREEN_MAX, SCREEN_MIN);
            default: h = 32'(SCREEN_MAX);
        endcase
        if ($urandom_range(2) == 0) begin
            case ($urandom_range(3))
                0: reg_writes.push_back('{CFG_SCREEN_WIDTH,
                                          CFG_DATA_W'($urandom_range(8191, 4097))});
                1: reg_writes.push_back('{CFG_SCREEN_HEIGHT, CFG_DATA_W'(0)});
                2: reg_writes.push_back('{CFG_CHAR_SCALE,
                                          CFG_DATA_W'($urandom_range(8191, 9))});
                default: reg_writes.push_back('{CFG_UNUSED,
                                                CFG_DATA_W'($urandom_range(8191))});
            endcase
        end
        reg_writes.push_back('{CFG_SCREEN_WIDTH, CFG_DATA_W'(w)});
        reg_writes.push_back('{CFG_SCREEN_HEIGHT, CFG_DATA_W'(h)});
        reg_writes.push_back('{CFG_CHAR_SCALE,
                               CFG_DATA_W'($urandom_range(SCALE_MAX, SCALE_MIN))});
    endtask

    task automatic test_directed_text();
        // Printable ends, control and DEL codes, code zero, newline, return,
        // bad lead bytes, box ends, the last braille code, a four-byte form,
        // an overlong letter and an overlong zero.
        put_string('{8'h20, 8'h7E, 8'h1F, 8'h7F, 8'h00, 8'h0A, 8'h0D,
                     8'h80, 8'hBF, 8'hF8, 8'hFF,
                     8'hE2, 8'h94, 8'h80, 8'hE2, 8'h95, 8'hBF,
                     8'hE2, 8'hA3, 8'hBF, 8'hF0, 8'h9F, 8'h98, 8'h80,
                     8'hC1, 8'h81, 8'hC0, 8'h80});
        // A lead byte taken as a continuation.
        put_string('{8'hE2, 8'hE0, 8'h41, 8'h41});
        drain_results();
    endtask

    task automatic test_screen_limits();
        reg_writes.push_back('{CFG_SCREEN_WIDTH, CFG_DATA_W'(0)});
        reg_writes.push_back('{CFG_SCREEN_WIDTH, CFG_DATA_W'(4097)});
        set_screen(SCREEN_MIN, SCREEN_MAX, SCALE_MIN);
        put_string('{8'h41, 8'h42, 8'h0D, 8'h43});
        drain_results();
        set_screen(SCREEN_MAX, SCREEN_MIN, SCALE_MAX);
        put_string('{8'h0A, 8'h5A, 8'h0A});
        drain_results();
        set_screen(SCREEN_MAX, SCREEN_MAX, SCALE_MAX);
        put_string('{8'h58, 8'h58, 8'h58, 8'h58, 8'h58, 8'h58, 8'h0A, 8'h0A,
                     8'h0A, 8'h58, 8'h58});
        drain_results();
        reg_writes.push_back('{CFG_CHAR_SCALE, CFG_DATA_W'(0)});
        reg_writes.push_back('{CFG_CHAR_SCALE, CFG_DATA_W'(9)});
        reg_writes.push_back('{CFG_CHAR_SCALE, CFG_DATA_W'(15)});
        reg_writes.push_back('{CFG_SCREEN_HEIGHT, CFG_DATA_W'(8191)});
        reg_writes.push_back('{CFG_UNUSED, CFG_DATA_W'(8191)});
        set_screen(100, 100, SCALE_MIN);
        put_string('{8'h41, 8'h0A, 8'h41});
        drain_results();
    endtask

    task automatic test_random_text(input int unsigned idle, input int unsigned stall,
                                    input int unsigned count);
        int unsigned start;
        idle_pct = idle;
        stall_pct = stall;
        queue_random_settings();
        write_regs();
        start = n_bytes;
        while (n_bytes - start < count) put_random_text();
        drain_results();
    endtask

    task automatic test_output_hold_off();
        int unsigned start;
        idle_pct = 0;
        stall_pct = 0;
        set_screen(200, 120, 2);
        hold_left = HOLD_CYCLES;
        start = n_bytes;
        while (n_bytes - start < 40) put_random_text();
        drain_results();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_text();
        test_screen_limits();
        test_random_text(0, 0, 190);
        test_random_text(45, 0, 190);
        test_random_text(0, 45, 190);
        test_random_text(20, 20, 190);
        test_output_hold_off();
        test_random_text(0, 0, 60);
        drain_results();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d text bytes under %0d register settings and four idle patterns.",
                 n_bytes, n_settings);
        $display("Checked %0d results: %0d glyph draws, %0d scroll requests.",
                 n_results, n_draws, n_scrolls);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
